// File: design/onp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// onp_pkg
// shared constants and register index codes for the oblique near plane block
// ----------------------------------------------------------------------------
package onp_pkg;

	// default number format, q16.16 in a 32-bit word
	localparam int DEF_FRAC_BITS = 16;
	localparam int DEF_WORD_BITS = 32;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_X_SCALE      = 3'd0,
		REG_Y_SCALE      = 3'd1,
		REG_X_OFFSET     = 3'd2,
		REG_Y_OFFSET     = 3'd3,
		REG_DEPTH_SCALE  = 3'd4,
		REG_DEPTH_OFFSET = 3'd5
	} cfg_reg_t;

	localparam int CFG_INDEX_BITS = $bits(cfg_reg_t);

endpackage

// File: design/onp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// onp_div
// pipelined unsigned restoring divider, one quotient bit per register stage
// ----------------------------------------------------------------------------
module onp_div #(
	parameter int DEN_BITS = 32,
	parameter int QUO_BITS = 33
) (
	input  logic                clk,
	input  logic                en,
	input  logic [DEN_BITS-1:0] rem_init,  // upper dividend bits, must be below den
	input  logic [QUO_BITS-1:0] num_low,   // dividend bits fed one per stage
	input  logic [DEN_BITS-1:0] den,
	output logic [QUO_BITS-1:0] quo
);

	// partial remainder and divisor, carried to every stage but the last
	logic [DEN_BITS-1:0] rem_s [1:QUO_BITS-1];
	logic [DEN_BITS-1:0] den_s [1:QUO_BITS-1];
	// remaining dividend bits shift out at the top, quotient bits shift in below
	logic [QUO_BITS-1:0] nq_s  [1:QUO_BITS];

	for (genvar j = 0; j < QUO_BITS; j++) begin : g_step
		logic [DEN_BITS-1:0] rem_in;
		logic [DEN_BITS-1:0] den_in;
		logic [QUO_BITS-1:0] nq_in;
		logic [DEN_BITS:0]   trial;
		logic                ge;

		if (j == 0) begin : g_first
			assign rem_in = rem_init;
			assign den_in = den;
			assign nq_in  = num_low;
		end else begin : g_next
			assign rem_in = rem_s[j];
			assign den_in = den_s[j];
			assign nq_in  = nq_s[j];
		end

		assign trial = {rem_in, nq_in[QUO_BITS-1]};
		assign ge    = trial >= {1'b0, den_in};

		always_ff @(posedge clk) begin
			if (en) begin
				nq_s[j+1] <= {nq_in[QUO_BITS-2:0], ge};
			end
		end

		if (j < QUO_BITS - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[j+1] <= ge ? DEN_BITS'(trial - {1'b0, den_in}) : trial[DEN_BITS-1:0];
					den_s[j+1] <= den_in;
				end
			end
		end
	end

	assign quo = nq_s[QUO_BITS];

endmodule

// File: design/oblique_near_plane_projection.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oblique_near_plane_projection
// replaces the third projection row so the near plane matches a clip plane
// ----------------------------------------------------------------------------
// usage
//  - s_axis carries one clip plane per request: a, b, c, d as signed fixed
//    point words; m_axis returns the four new third-row entries and, on
//    tuser, a degenerate flag (zero divisor, zero dot product or saturation)
//  - the six projection entries sit in registers written through cfg_wr_en,
//    cfg_index and cfg_data; write them only while no request is in flight
//  - one request is taken every cycle unless the output stalls; the depth
//    comes from two restoring divider pipelines, the far-corner one with
//    WORD_BITS+FRAC_BITS+1 stages and the scale one with WORD_BITS+1 stages,
//    one quotient bit each
//  - reset clears every valid bit and loads the identity-like defaults
//    (scales 1.0, offsets 0, depth scale and depth offset -1.0)
//  - while a result waits in the output register and m_axis_tready is low the
//    whole pipeline holds and s_axis_tready drops; bubbles in flight are kept
// ----------------------------------------------------------------------------
module oblique_near_plane_projection
	import onp_pkg::*;
#(
	parameter int FRAC_BITS = DEF_FRAC_BITS,
	parameter int WORD_BITS = DEF_WORD_BITS,
	localparam int TDATA_BITS = ((4 * WORD_BITS + 7) / 8) * 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration write port
	input  logic                      cfg_wr_en,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [WORD_BITS-1:0]      cfg_data,
	// plane requests
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [TDATA_BITS-1:0]     s_axis_tdata,   // plane_a, plane_b, plane_c, plane_d
	// projection row results
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [TDATA_BITS-1:0]     m_axis_tdata,   // row2_col0, row2_col1, row2_col2, row2_col3
	output logic                      m_axis_tuser    // degenerate
);

	localparam int W   = WORD_BITS;
	localparam int F   = FRAC_BITS;
	localparam int NM  = W + 1;            // far-corner numerator magnitude
	localparam int K1  = NM + F;           // far-corner quotient bits
	localparam int QW  = K1 + 1;           // signed far-corner component
	localparam int DW  = 2 * W + F + 3;    // signed dot product
	localparam int DM  = DW - 1;           // dot product magnitude
	localparam int K2  = W + 1;            // scale quotient bits kept
	localparam int NB2 = K2 + 2 * F;       // scaled plane numerator, |p| << (2F+1)
	localparam int SW  = W + 3;            // final sum before saturation
	localparam int LAT = 12 + K1 + K2;

	localparam logic signed [W+1:0] ONE_N   = (W + 2)'(1) <<< F;
	localparam logic signed [W-1:0] ONE_W   = W'(1) << F;
	localparam logic signed [W-1:0] WMAX    = {1'b0, {(W - 1){1'b1}}};
	localparam logic signed [W-1:0] WMIN    = {1'b1, {(W - 1){1'b0}}};

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic signed [W-1:0] x_scale_q, y_scale_q, x_off_q, y_off_q, d_scale_q, d_off_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_scale_q <= ONE_W;
			y_scale_q <= ONE_W;
			x_off_q   <= '0;
			y_off_q   <= '0;
			d_scale_q <= -ONE_W;
			d_off_q   <= -ONE_W;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_X_SCALE:      x_scale_q <= cfg_data;
				REG_Y_SCALE:      y_scale_q <= cfg_data;
				REG_X_OFFSET:     x_off_q   <= cfg_data;
				REG_Y_OFFSET:     y_off_q   <= cfg_data;
				REG_DEPTH_SCALE:  d_scale_q <= cfg_data;
				REG_DEPTH_OFFSET: d_off_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// flow control: one global enable, the pipeline moves unless the
	// output register holds a result that is not taken
	// ------------------------------------------------------------------
	logic           en;
	logic [LAT:1]   vld_s;

	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_s[LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-1:1], s_axis_tvalid};
		end
	end

	// sign of a plane component scaled to one, zero stays zero
	function automatic logic signed [W+1:0] sgn_one(input logic [W-1:0] v);
		if (v == '0) begin
			return '0;
		end else if (v[W-1]) begin
			return -ONE_N;
		end else begin
			return ONE_N;
		end
	endfunction

	// ------------------------------------------------------------------
	// s1: capture the plane
	// ------------------------------------------------------------------
	logic [3:0][W-1:0] p_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= s_axis_tdata[4*W-1:0];
		end
	end

	// ------------------------------------------------------------------
	// s2: far-corner numerators sgn(a)+x_off, sgn(b)+y_off, 1+depth_scale
	// ------------------------------------------------------------------
	logic [2:0][W+1:0] n_s2;
	logic [3:0][W-1:0] p_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			n_s2[0] <= sgn_one(p_s1[0]) + (W + 2)'(x_off_q);
			n_s2[1] <= sgn_one(p_s1[1]) + (W + 2)'(y_off_q);
			n_s2[2] <= ONE_N + (W + 2)'(d_scale_q);
			p_s2    <= p_s1;
		end
	end

	// ------------------------------------------------------------------
	// s3: magnitudes and signs for the far-corner dividers
	// ------------------------------------------------------------------
	logic [2:0][W-1:0]  scale_c;
	logic [2:0][NM-1:0] nm_s3;
	logic [2:0][W-1:0]  dm_s3;
	logic [2:0]         qneg_s3;
	logic [2:0]         dz_s3;
	logic [3:0][W-1:0]  p_s3;

	assign scale_c = {d_off_q, y_scale_q, x_scale_q};

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				nm_s3[i]   <= n_s2[i][W+1] ? NM'(-n_s2[i]) : n_s2[i][W:0];
				dm_s3[i]   <= scale_c[i][W-1] ? -scale_c[i] : scale_c[i];
				qneg_s3[i] <= n_s2[i][W+1] ^ scale_c[i][W-1];
				dz_s3[i]   <= scale_c[i] == '0;
			end
			p_s3 <= p_s2;
		end
	end

	// ------------------------------------------------------------------
	// far-corner division, numerator << FRAC_BITS over the scale
	// ------------------------------------------------------------------
	typedef struct packed {
		logic [3:0][W-1:0] p;
		logic [2:0]        qneg;
		logic [2:0]        dz;
	} d1_t;

	logic [2:0][K1-1:0] qm1;
	d1_t                d1_s [1:K1];

	for (genvar i = 0; i < 3; i++) begin : g_div1
		onp_div #(
			.DEN_BITS (W),
			.QUO_BITS (K1)
		) u_div (
			.clk      (clk),
			.en       (en),
			.rem_init ('0),
			.num_low  ({nm_s3[i], {F{1'b0}}}),
			.den      (dm_s3[i]),
			.quo      (qm1[i])
		);
	end

	// side data that rides along with the divider stages
	always_ff @(posedge clk) begin
		if (en) begin
			d1_s[1] <= '{p: p_s3, qneg: qneg_s3, dz: dz_s3};
			for (int j = 2; j <= K1; j++) begin
				d1_s[j] <= d1_s[j-1];
			end
		end
	end

	// ------------------------------------------------------------------
	// s4: signed far-corner components, forced to zero on a zero divisor
	// ------------------------------------------------------------------
	logic [2:0][QW-1:0] q_s4;
	logic               flag_s4;
	logic [3:0][W-1:0]  p_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				q_s4[i] <= d1_s[K1].dz[i] ? '0 :
					(d1_s[K1].qneg[i] ? -{1'b0, qm1[i]} : {1'b0, qm1[i]});
			end
			flag_s4 <= |d1_s[K1].dz;
			p_s4    <= d1_s[K1].p;
		end
	end

	// ------------------------------------------------------------------
	// s5: partial products, q split into a low unsigned word and a high part
	// ------------------------------------------------------------------
	logic [2:0][W-1:0]     mp_s4;
	logic [2:0][2*W:0]     pl_s5;
	logic [2:0][F+W+1:0]   ph_s5;
	logic                  flag_s5;
	logic [3:0][W-1:0]     p_s5;

	// q components pair with a, b and d
	assign mp_s4 = {p_s4[3], p_s4[1], p_s4[0]};

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pl_s5[i] <= $signed({1'b0, q_s4[i][W-1:0]}) * $signed(mp_s4[i]);
				ph_s5[i] <= $signed(q_s4[i][QW-1:W]) * $signed(mp_s4[i]);
			end
			flag_s5 <= flag_s4;
			p_s5    <= p_s4;
		end
	end

	// ------------------------------------------------------------------
	// s6: full products
	// ------------------------------------------------------------------
	logic [2:0][DW-1:0] prod_s6;
	logic               flag_s6;
	logic [3:0][W-1:0]  p_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				prod_s6[i] <= (DW'($signed(ph_s5[i])) <<< W) + DW'($signed(pl_s5[i]));
			end
			flag_s6 <= flag_s5;
			p_s6    <= p_s5;
		end
	end

	// ------------------------------------------------------------------
	// s7: pair sums, c enters with the far-corner z of -1
	// ------------------------------------------------------------------
	logic [DW-1:0]     sxy_s7, swc_s7;
	logic              flag_s7;
	logic [3:0][W-1:0] p_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			sxy_s7  <= prod_s6[0] + prod_s6[1];
			swc_s7  <= prod_s6[2] - (DW'($signed(p_s6[2])) <<< F);
			flag_s7 <= flag_s6;
			p_s7    <= p_s6;
		end
	end

	// ------------------------------------------------------------------
	// s8: dot product, 2*FRAC_BITS fraction bits
	// ------------------------------------------------------------------
	logic [DW-1:0]     dot_s8;
	logic              flag_s8;
	logic [3:0][W-1:0] p_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			dot_s8  <= sxy_s7 + swc_s7;
			flag_s8 <= flag_s7;
			p_s8    <= p_s7;
		end
	end

	// ------------------------------------------------------------------
	// s9: magnitudes and signs of the dot product and the plane
	// ------------------------------------------------------------------
	logic [DM-1:0]     dmag_s9;
	logic              dneg_s9, dzero_s9, flag_s9;
	logic [3:0][W-1:0] pmag_s9;
	logic [3:0]        pneg_s9, pz_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			dmag_s9  <= dot_s8[DW-1] ? DM'(-dot_s8) : dot_s8[DM-1:0];
			dneg_s9  <= dot_s8[DW-1];
			dzero_s9 <= dot_s8 == '0;
			for (int i = 0; i < 4; i++) begin
				pmag_s9[i] <= p_s8[i][W-1] ? -p_s8[i] : p_s8[i];
				pneg_s9[i] <= p_s8[i][W-1];
				pz_s9[i]   <= p_s8[i] == '0;
			end
			flag_s9 <= flag_s8;
		end
	end

	// ------------------------------------------------------------------
	// s10: split 2*p << 2F into the part that decides saturation and the
	// WORD_BITS+1 low bits that the scale divider works through
	// ------------------------------------------------------------------
	logic [3:0][NB2-1:0] n2_c;
	logic [3:0][DM-1:0]  rem_s10;
	logic [3:0][K2-1:0]  low_s10;
	logic [DM-1:0]       den_s10;
	logic [3:0]          ovf_s10, neg_s10, pz_s10;
	logic                flag_s10;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			n2_c[i] = {pmag_s9[i], {(2 * F + 1){1'b0}}};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				rem_s10[i] <= DM'(n2_c[i][NB2-1:K2]);
				low_s10[i] <= n2_c[i][K2-1:0];
				// a zero dot product or a quotient of 2^K2 or more saturates
				ovf_s10[i] <= !pz_s9[i] && (dzero_s9 || (DM'(n2_c[i][NB2-1:K2]) >= dmag_s9));
				neg_s10[i] <= pneg_s9[i] ^ dneg_s9;
				pz_s10[i]  <= pz_s9[i];
			end
			den_s10  <= dmag_s9;
			flag_s10 <= flag_s9 | dzero_s9;
		end
	end

	// ------------------------------------------------------------------
	// scale division, 2*p << 2F over the dot product
	// ------------------------------------------------------------------
	typedef struct packed {
		logic [3:0] ovf;
		logic [3:0] neg;
		logic [3:0] pz;
		logic       flag;
	} d2_t;

	logic [3:0][K2-1:0] qm2;
	d2_t                d2_s [1:K2];

	for (genvar i = 0; i < 4; i++) begin : g_div2
		onp_div #(
			.DEN_BITS (DM),
			.QUO_BITS (K2)
		) u_div (
			.clk      (clk),
			.en       (en),
			.rem_init (rem_s10[i]),
			.num_low  (low_s10[i]),
			.den      (den_s10),
			.quo      (qm2[i])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d2_s[1] <= '{ovf: ovf_s10, neg: neg_s10, pz: pz_s10, flag: flag_s10};
			for (int j = 2; j <= K2; j++) begin
				d2_s[j] <= d2_s[j-1];
			end
		end
	end

	// ------------------------------------------------------------------
	// s11: signed scaled components, a zero plane component stays zero
	// ------------------------------------------------------------------
	logic [3:0][W+1:0] val_s11;
	logic [3:0]        ovf_s11, neg_s11;
	logic              flag_s11;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				val_s11[i] <= d2_s[K2].pz[i] ? '0 :
					(d2_s[K2].neg[i] ? -{1'b0, qm2[i]} : {1'b0, qm2[i]});
			end
			ovf_s11  <= d2_s[K2].ovf;
			neg_s11  <= d2_s[K2].neg;
			flag_s11 <= d2_s[K2].flag;
		end
	end

	// ------------------------------------------------------------------
	// s12: add one to the c entry, saturate, output register
	// ------------------------------------------------------------------
	logic [3:0][SW-1:0] sum_c;
	logic [3:0][W-1:0]  res_c;
	logic [3:0]         sat_c;
	logic [3:0][W-1:0]  row_s12;
	logic               degen_s12;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			sum_c[i] = SW'($signed(val_s11[i])) + ((i == 2) ? SW'(ONE_N) : '0);
			if (ovf_s11[i]) begin
				res_c[i] = neg_s11[i] ? WMIN : WMAX;
				sat_c[i] = 1'b1;
			end else if ($signed(sum_c[i]) > $signed(SW'(WMAX))) begin
				res_c[i] = WMAX;
				sat_c[i] = 1'b1;
			end else if ($signed(sum_c[i]) < $signed(SW'(WMIN))) begin
				res_c[i] = WMIN;
				sat_c[i] = 1'b1;
			end else begin
				res_c[i] = sum_c[i][W-1:0];
				sat_c[i] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			row_s12   <= res_c;
			degen_s12 <= flag_s11 | (|sat_c);
		end
	end

	assign m_axis_tdata = TDATA_BITS'(row_s12);
	assign m_axis_tuser = degen_s12;

endmodule
